FILE: hdl/wwlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwlc_pkg
// Shared types, codes and helpers for the word wrap line counter.
// ----------------------------------------------------------------------------
package wwlc_pkg;

    localparam int DATA_W    = 16;
    localparam int GLYPH_W   = 7;
    localparam int CODE_W    = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] GLYPH_BASE  = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CODE_W-1:0] CHAR_PERIOD = 8'h2E;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    typedef enum logic [1:0] {
        KIND_LETTER,
        KIND_SPACE,
        KIND_BREAK
    } wwlc_kind_t;

    typedef struct packed {
        wwlc_kind_t         kind;
        logic [GLYPH_W-1:0] glyph_w;
        logic               last;
    } wwlc_item_t;

    function automatic logic [DATA_W-1:0] sat_add16(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
    endfunction

endpackage

FILE: hdl/word_wrap_line_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_wrap_line_counter_core
// Greedy word wrap line counter with a loadable glyph width store.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one word per character or glyph load. tuser selects the
//   kind (0 loads a glyph width, 1 feeds a text character), tlast marks the
//   final character of a string.
//   m_* returns the line count of a string, one word per string.
//   cfg_wr_en / cfg_wr_data write the line width in pixels; write it only
//   while no string is in flight.
// timing:
//   one word per cycle in and out while m_tready stays high. the front
//   reads the glyph width memory through its single registered port and
//   the back updates the line state registers directly from the queue
//   head, so the rate is one character per clock. the final character of
//   a string passes the front stage and the queue to the result register.
// reset and stalls:
//   reset clears line state, queue and wrap width; glyph widths are
//   undefined until loaded. when m_tready is low the result holds, the
//   four-entry queue and the front stage fill, then s_tready drops.
// ----------------------------------------------------------------------------
module word_wrap_line_counter_core
    import wwlc_pkg::*;
#(
    parameter int GLYPH_COUNT = 224,
    parameter int WIDTH_CAP   = 100
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // wrap_width
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // char_code [7:0], width_value [23:8]
    input  logic        s_tuser,       // func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // line_count
);

    logic [DATA_W-1:0] wrap_width_reg;
    logic              push_valid;
    logic              push_ready;
    wwlc_item_t        push_data;
    logic              pop_valid;
    logic              pop_ready;
    wwlc_item_t        pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrap_width_reg <= '0;
        else if (cfg_wr_en)
            wrap_width_reg <= cfg_wr_data;
    end

    wwlc_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .WIDTH_CAP   (WIDTH_CAP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_code    (s_tdata[7:0]),
        .in_width   (s_tdata[23:8]),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    wwlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wwlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wrap_width (wrap_width_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_count  (m_tdata)
    );

    // a string always occupies at least one line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != '0)
        else $error("line count of zero");

    // a blocked result must keep the back from taking another character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !pop_ready)
        else $error("back popped into a blocked result register");

    // a character waiting for queue space stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> push_valid && $stable(push_data))
        else $error("front dropped or changed a stalled character");

endmodule

FILE: hdl/wwlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwlc_front
// Accepts words, loads the glyph width memory and classifies text characters.
// ----------------------------------------------------------------------------
module wwlc_front
    import wwlc_pkg::*;
#(
    parameter int GLYPH_COUNT = 224,
    parameter int WIDTH_CAP   = 100
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_func,
    input  logic [CODE_W-1:0] in_code,
    input  logic [DATA_W-1:0] in_width,
    input  logic              in_last,
    output logic              push_valid,
    input  logic              push_ready,
    output wwlc_item_t        push_data
);

    localparam int AW = $clog2(GLYPH_COUNT);
    localparam logic [GLYPH_W-1:0] CAP = GLYPH_W'(WIDTH_CAP);

    logic [GLYPH_W-1:0] glyph_mem [GLYPH_COUNT];

    logic               st_valid_reg;
    wwlc_kind_t         st_kind_reg;
    logic               st_last_reg;
    logic               st_hit_reg;
    logic [GLYPH_W-1:0] rd_data_reg;

    logic [CODE_W-1:0]  idx;
    logic               in_range;
    logic [AW-1:0]      addr;
    logic               accept;
    logic [GLYPH_W-1:0] capped;
    wwlc_kind_t         kind;

    assign idx      = in_code - GLYPH_BASE;
    assign in_range = {1'b0, idx} < (CODE_W + 1)'(GLYPH_COUNT);
    assign addr     = idx[AW-1:0];
    assign in_ready = !st_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign capped   = (in_width > DATA_W'(CAP)) ? CAP : in_width[GLYPH_W-1:0];

    always_comb
    begin
        case (in_code)
            CHAR_SPACE:               kind = KIND_SPACE;
            CHAR_HYPHEN, CHAR_PERIOD: kind = KIND_BREAK;
            default:                  kind = KIND_LETTER;
        endcase
    end

    // glyph width store, one write or one read per word
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            if (in_func == FUNC_LOAD)
                glyph_mem[addr] <= capped;
            else
                rd_data_reg <= glyph_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_kind_reg <= kind;
            st_last_reg <= in_last;
            st_hit_reg  <= in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (accept)
            st_valid_reg <= (in_func == FUNC_TEXT);
        else if (push_ready)
            st_valid_reg <= 1'b0;
    end

    assign push_valid        = st_valid_reg;
    assign push_data.kind    = st_kind_reg;
    assign push_data.glyph_w = st_hit_reg ? rd_data_reg : '0;
    assign push_data.last    = st_last_reg;

endmodule

FILE: hdl/wwlc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwlc_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module wwlc_queue
    import wwlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  wwlc_item_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output wwlc_item_t pop_data
);

    wwlc_item_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: hdl/wwlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwlc_back
// Line position, word width and wrap count update, with the result register.
// ----------------------------------------------------------------------------
module wwlc_back
    import wwlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DATA_W-1:0] wrap_width,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  wwlc_item_t        pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_count
);

    logic [DATA_W-1:0] line_pos_reg,   line_pos_next;
    logic [DATA_W-1:0] word_width_reg, word_width_next;
    logic [DATA_W-1:0] wraps_reg,      wraps_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_count_reg;

    logic              fire;
    logic [DATA_W-1:0] glyph;
    logic [DATA_W-1:0] ww_add;
    logic [DATA_W-1:0] fit_ww;
    logic [DATA_W:0]   fit_sum;
    logic              do_fit;
    logic              wrap;
    logic [DATA_W-1:0] lp_wrapped;

    assign pop_ready = !out_valid_reg || out_ready;
    assign fire      = pop_valid && pop_ready;
    assign glyph     = DATA_W'(pop_data.glyph_w);
    assign ww_add    = sat_add16(word_width_reg, glyph);
    assign fit_ww    = (pop_data.kind == KIND_SPACE) ? word_width_reg : ww_add;
    assign fit_sum   = {1'b0, line_pos_reg} + {1'b0, fit_ww};
    // a trailing letter leaves a pending word that still gets the fit test
    assign do_fit    = (pop_data.kind != KIND_LETTER) || pop_data.last;
    assign wrap      = do_fit && (fit_sum > {1'b0, wrap_width}) && (line_pos_reg != '0);
    assign lp_wrapped = wrap ? '0 : line_pos_reg;

    always_comb
    begin
        wraps_next = wrap ? sat_add16(wraps_reg, DATA_W'(1)) : wraps_reg;
        case (pop_data.kind)
            KIND_SPACE:
            begin
                line_pos_next   = sat_add16(sat_add16(lp_wrapped, word_width_reg), glyph);
                word_width_next = '0;
            end
            KIND_BREAK:
            begin
                line_pos_next   = sat_add16(lp_wrapped, ww_add);
                word_width_next = '0;
            end
            default:
            begin
                line_pos_next   = lp_wrapped;
                word_width_next = ww_add;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg   <= '0;
            word_width_reg <= '0;
            wraps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (pop_data.last)
                begin
                    line_pos_reg   <= '0;
                    word_width_reg <= '0;
                    wraps_reg      <= '0;
                end
                else
                begin
                    line_pos_reg   <= line_pos_next;
                    word_width_reg <= word_width_next;
                    wraps_reg      <= wraps_next;
                end
            end
            if (fire && pop_data.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && pop_data.last)
            out_count_reg <= sat_add16(wraps_next, DATA_W'(1));
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the word wrap line counter core.
// ----------------------------------------------------------------------------
// Streams glyph width loads and text strings into the block and predicts the
// line count of each string with a cycle-free model of greedy word wrap.
// Every returned line count is compared with the oldest prediction. The run
// starts with a short directed part, then goes through several line widths
// with random strings, and ends on one very long word at the widest setting.
// Random gaps on the input side and random back pressure on the output side
// come and go, with bursts of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb;
    import wwlc_pkg::*;

    localparam int GLYPHS      = 224;
    localparam int CAP         = 100;
    localparam int MAX_GAP     = 8;
    localparam int SETTLE      = 12;
    localparam int DRAIN_LIMIT = 5000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 130;
    localparam int LONG_WORD   = 660;
    localparam int SHOW_LIMIT  = 10;

    localparam logic [CODE_W-1:0] CHAR_WIDE = 8'h57;
    localparam logic [DATA_W-1:0] WIDTH_MAX = 16'hFFFF;

    class line_tally;
        bit   [GLYPH_W-1:0] glyph_w [GLYPHS];
        logic [DATA_W-1:0]  wrap_w    = '0;
        logic [DATA_W-1:0]  line_pos  = '0;
        logic [DATA_W-1:0]  word_w    = '0;
        logic [DATA_W-1:0]  wraps     = '0;
        bit                 pending   = 1'b0;
        logic [DATA_W-1:0]  expected_counts [$];
        int                 errors    = 0;
        int                 n_loads   = 0;
        int                 n_chars   = 0;
        int                 n_strings = 0;

        function logic [DATA_W-1:0] clip_add(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
            logic [DATA_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return (s > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : s[DATA_W-1:0];
        endfunction

        // wrap when the word overflows the line and the line holds something
        function void fit_line();
            if (({1'b0, line_pos} + {1'b0, word_w} > {1'b0, wrap_w}) && line_pos != 0)
            begin
                line_pos = '0;
                wraps    = clip_add(wraps, 16'd1);
            end
        endfunction

        function void fault(input string msg);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void note_word(input logic func, input logic [CODE_W-1:0] code,
                                input logic [DATA_W-1:0] wv, input logic last);
            logic [CODE_W-1:0] idx;
            logic [DATA_W-1:0] gw;
            idx = code - GLYPH_BASE;
            if (func == FUNC_LOAD)
            begin
                n_loads++;
                if (idx < GLYPHS)
                    glyph_w[idx] = (wv > CAP) ? CAP[GLYPH_W-1:0] : wv[GLYPH_W-1:0];
                return;
            end
            n_chars++;
            gw = (idx < GLYPHS) ? {{(DATA_W-GLYPH_W){1'b0}}, glyph_w[idx]} : '0;
            if (code == CHAR_SPACE)
            begin
                fit_line();
                line_pos = clip_add(line_pos, word_w);
                line_pos = clip_add(line_pos, gw);
                word_w   = '0;
                pending  = 1'b0;
            end
            else if (code == CHAR_HYPHEN || code == CHAR_PERIOD)
            begin
                word_w = clip_add(word_w, gw);
                fit_line();
                line_pos = clip_add(line_pos, word_w);
                word_w   = '0;
                pending  = 1'b0;
            end
            else
            begin
                word_w  = clip_add(word_w, gw);
                pending = 1'b1;
            end
            if (last)
            begin
                if (pending)
                    fit_line();
                expected_counts.push_back(clip_add(wraps, 16'd1));
                line_pos = '0;
                word_w   = '0;
                pending  = 1'b0;
                wraps    = '0;
            end
        endfunction

        function void check_count(input logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_counts.size() == 0)
            begin
                fault($sformatf("line count %0d with no string pending", got));
                return;
            end
            want = expected_counts.pop_front();
            n_strings++;
            if (got !== want)
                fault($sformatf("line count expected %0d actual %0d", want, got));
        endfunction

        function void drain_check();
            while (expected_counts.size() != 0)
                fault($sformatf("line count %0d never returned",
                                expected_counts.pop_front()));
        endfunction
    endclass

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en;
    logic [15:0]       cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;     // char_code [7:0], width_value [23:8]
    logic              s_tuser;     // func
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;     // line_count

    line_tally         sb = new;
    bit                src_burst  = 1'b0;
    bit                snk_burst  = 1'b0;
    int                words_sent = 0;
    int                n_settings = 0;

    word_wrap_line_counter_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_count(m_tdata);
    end

    function automatic logic [DATA_W-1:0] pick_width();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 24));
    endfunction

    task automatic send_word(input logic func, input logic [CODE_W-1:0] code,
                             input logic [DATA_W-1:0] wv, input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {wv, code};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_word(func, code, wv, last);
        words_sent++;
    endtask

    task automatic load_glyph(input logic [CODE_W-1:0] code, input logic [DATA_W-1:0] wv);
        send_word(FUNC_LOAD, code, wv, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(FUNC_TEXT, txt[i], 16'($urandom), i == txt.len() - 1);
    endtask

    // mostly letters, some breaks, now and then a glyph reload mid string
    task automatic random_string();
        int                len;
        int                r;
        logic [CODE_W-1:0] code;
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                load_glyph(8'($urandom_range(32, 255)), pick_width());
            r = $urandom_range(0, 9);
            if (r < 2)
                code = CHAR_SPACE;
            else if (r == 2)
                code = CHAR_HYPHEN;
            else if (r == 3)
                code = CHAR_PERIOD;
            else
                code = 8'($urandom_range(33, 255));
            send_word(FUNC_TEXT, code, 16'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.expected_counts.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_wrap(input logic [DATA_W-1:0] w);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        sb.wrap_w = w;
        n_settings++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 19) == 0)
                snk_burst = !snk_burst;
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int               start;
        logic [DATA_W-1:0] w;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tuser     = FUNC_LOAD;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: capped, zero and odd glyph widths, then short strings
        set_wrap(16'd250);
        load_glyph(CHAR_SPACE, WIDTH_MAX);
        load_glyph(CHAR_HYPHEN, 16'd0);
        load_glyph(CHAR_PERIOD, 16'd101);
        load_glyph("a", 16'd40);
        load_glyph("b", 16'd100);
        load_glyph(8'hFF, 16'd7);
        load_glyph("c", 16'd60);
        send_text("b b b");
        send_text("a.c-\377");
        send_text(" ");
        send_text("bbb  a");

        // fill every glyph so later strings never hit an unloaded width
        for (int c = 32; c <= 255; c++)
            load_glyph(8'(c), pick_width());

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                w = '0;
            else if (ph == 1)
                w = WIDTH_MAX;
            else if ($urandom_range(0, 3) == 0)
                w = 16'($urandom_range(0, 65535));
            else
                w = 16'($urandom_range(10, 600));
            set_wrap(w);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
                random_string();
        end

        // one word long enough to saturate the line position
        set_wrap(WIDTH_MAX);
        load_glyph(CHAR_WIDE, 16'(CAP));
        for (int i = 0; i < LONG_WORD; i++)
            send_word(FUNC_TEXT, CHAR_WIDE, 16'($urandom), 1'b0);
        send_word(FUNC_TEXT, CHAR_SPACE, 16'($urandom), 1'b0);
        send_word(FUNC_TEXT, CHAR_WIDE, 16'($urandom), 1'b0);
        send_word(FUNC_TEXT, CHAR_PERIOD, 16'($urandom), 1'b1);

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        sb.drain_check();

        $display("run covered %0d glyph loads and %0d text characters over %0d line widths",
                 sb.n_loads, sb.n_chars, n_settings);
        $display("%0d line counts checked, %0d failures", sb.n_strings, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting for the line counter");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: word_wrap_line_counter_core.f
hdl/wwlc_pkg.sv
hdl/wwlc_front.sv
hdl/wwlc_queue.sv
hdl/wwlc_back.sv
hdl/word_wrap_line_counter_core.sv
verif/tb.sv
